@@ rtl/stk_pkg.sv @@
// Shared constants, types and helpers for the streaming top-k selector.
package stk_pkg;

    localparam int K_MAX     = 8;
    localparam int MAX_ITEMS = 262144;

    localparam int SCORE_W   = 32;
    localparam int IDX_W     = 18;
    localparam int KCFG_W    = 4;
    localparam int POS_W     = $clog2(MAX_ITEMS);
    localparam int K_W       = $clog2(K_MAX + 1);
    localparam int RANK_W    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int MTDATA_W  = ((IDX_W + SCORE_W + 7) / 8) * 8;

    localparam logic [KCFG_W-1:0] K_RESET = KCFG_W'(4);
    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(MAX_ITEMS - 1);
    localparam logic [SCORE_W-1:0] SCORE_MOST_NEG = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [IDX_W-1:0]          index_t;
    typedef logic [K_W-1:0]            kcnt_t;

    // One classified item on its way from the front to the insertion list.
    typedef struct packed {
        score_t score;
        index_t index;
        logic   last;
        kcnt_t  k;
    } item_t;

    // A register value of zero acts as one, and anything above K_MAX as K_MAX.
    function automatic kcnt_t active_k(input logic [KCFG_W-1:0] cfg);
        kcnt_t k;
        k = K_W'(1);
        if (int'(cfg) > K_MAX)
        begin
            k = K_W'(K_MAX);
        end
        else if (cfg != '0)
        begin
            k = K_W'(cfg);
        end
        return k;
    endfunction

endpackage

@@ rtl/stk_front.sv @@
// Front end: holds the k register, numbers each score and tags it with the active k.
module stk_front import stk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KCFG_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  score_t            in_score,
    input  logic              in_last,
    input  logic              q_full,
    output logic              q_push,
    output item_t             q_item
);

    logic [KCFG_W-1:0] k_reg;
    logic [KCFG_W-1:0] k_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.score = in_score;
        q_item.index = IDX_W'(pos_reg);
        q_item.last  = in_last;
        q_item.k     = active_k(k_reg);
    end

    always_comb
    begin
        k_next   = cfg_we ? cfg_wdata : k_reg;
        pos_next = pos_reg;
        if (q_push)
        begin
            // The position restarts after the last item and sticks at its limit.
            if (in_last)
            begin
                pos_next = '0;
            end
            else if (pos_reg < POS_LIMIT)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= K_RESET;
            pos_reg <= '0;
        end
        else
        begin
            k_reg   <= k_next;
            pos_reg <= pos_next;
        end
    end

endmodule

@@ rtl/stk_queue.sv @@
// The queue between the front and back ends is the stk_fifo module.

@@ rtl/stk_fifo.sv @@
// Short FIFO that decouples the front end from the insertion list.
module stk_fifo import stk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output item_t head,
    output logic  head_valid,
    input  logic  pop
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/stk_back.sv @@
// Back end: parallel compare-and-shift insertion list and the result drain buffer.
module stk_back import stk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  item_t               head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [IDX_W-1:0]    out_index,
    output score_t              out_score,
    output logic                out_filled,
    output logic                out_last
);

    score_t            score_reg [K_MAX];
    index_t            index_reg [K_MAX];
    logic [K_MAX-1:0]  valid_reg;

    score_t            score_next [K_MAX];
    index_t            index_next [K_MAX];
    logic [K_MAX-1:0]  valid_next;

    score_t            eb_score_reg [K_MAX];
    index_t            eb_index_reg [K_MAX];
    logic [K_MAX-1:0]  eb_valid_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    kcnt_t             emit_k_reg;
    kcnt_t             emit_k_next;

    logic [K_MAX-1:0]  better;
    logic [K_MAX-1:0]  shift_down;
    logic              emit_free;
    logic              load_emit;

    // A slot wins when it lies below k and is empty or holds a lower score.
    always_comb
    begin
        for (int j = 0; j < K_MAX; j++)
        begin
            better[j] = (j < int'(head.k)) && (!valid_reg[j] || (head.score > score_reg[j]));
        end
        shift_down[0] = 1'b0;
        for (int m = 1; m < K_MAX; m++)
        begin
            shift_down[m] = shift_down[m-1] || better[m-1];
        end
    end

    // Slots past the insertion point shift down by one; the first winning slot takes the item.
    always_comb
    begin
        for (int m = 0; m < K_MAX; m++)
        begin
            score_next[m] = score_reg[m];
            index_next[m] = index_reg[m];
            valid_next[m] = valid_reg[m];
            if (shift_down[m])
            begin
                score_next[m] = score_reg[(m > 0) ? m - 1 : 0];
                index_next[m] = index_reg[(m > 0) ? m - 1 : 0];
                valid_next[m] = valid_reg[(m > 0) ? m - 1 : 0];
            end
            else if (better[m])
            begin
                score_next[m] = head.score;
                index_next[m] = head.index;
                valid_next[m] = 1'b1;
            end
        end
    end

    assign m_tvalid   = busy_reg;
    assign out_last   = (rank_reg == RANK_W'(emit_k_reg - K_W'(1)));
    assign out_filled = eb_valid_reg[rank_reg];
    assign out_index  = eb_valid_reg[rank_reg] ? eb_index_reg[rank_reg] : '0;
    assign out_score  = eb_valid_reg[rank_reg] ? eb_score_reg[rank_reg] : score_t'(SCORE_MOST_NEG);

    // A last item may load the drain buffer in the cycle its previous run finishes.
    assign emit_free  = !busy_reg || (m_tready && out_last);
    assign pop        = head_valid && (!head.last || emit_free);
    assign load_emit  = pop && head.last;

    always_comb
    begin
        busy_next   = busy_reg;
        rank_next   = rank_reg;
        emit_k_next = emit_k_reg;
        if (load_emit)
        begin
            busy_next   = 1'b1;
            rank_next   = '0;
            emit_k_next = head.k;
        end
        else if (busy_reg && m_tready)
        begin
            if (out_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            busy_reg   <= 1'b0;
            rank_reg   <= '0;
            emit_k_reg <= K_W'(1);
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= head.last ? '0 : valid_next;
            end
            busy_reg   <= busy_next;
            rank_reg   <= rank_next;
            emit_k_reg <= emit_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int m = 0; m < K_MAX; m++)
            begin
                score_reg[m] <= score_next[m];
                index_reg[m] <= index_next[m];
            end
        end
        if (load_emit)
        begin
            eb_valid_reg <= valid_next;
            for (int m = 0; m < K_MAX; m++)
            begin
                eb_score_reg[m] <= score_next[m];
                eb_index_reg[m] <= index_next[m];
            end
        end
    end

endmodule

@@ rtl/streaming_top_k_selector_core.sv @@
// Top level of the streaming top-k selector.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata = score, s_tlast = last_item
//  m_*      out  m_tvalid/m_tready  m_tdata = rank_index, rank_score;
//                                   m_tuser = slot_filled; m_tlast = last_rank
//  cfg_*    in   cfg_we             cfg_wdata = k_in_use
//
// Scores are taken one per cycle unless the queue is full; each is compared in parallel.
// A last item produces k results from a drain buffer, one per cycle unless stalled;
// a later last item waits in the four-entry queue only while an earlier run drains.
// Reset empties the list, sets k_in_use to 4 and the stream position to zero.
// A stalled output holds its result; scores keep flowing until a later last item
// waits at the queue head, after which the queue fills and s_tready drops.
module streaming_top_k_selector_core import stk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [KCFG_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SCORE_W-1:0]  s_tdata,   // [31:0] score
    input  logic                s_tlast,   // last_item
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [MTDATA_W-1:0] m_tdata,   // [17:0] rank_index, [49:18] rank_score, zero pad
    output logic [0:0]          m_tuser,   // [0] slot_filled
    output logic                m_tlast    // last_rank
);

    logic               q_full;
    logic               q_push;
    item_t              q_item;
    item_t              q_head;
    logic               q_head_valid;
    logic               q_pop;
    logic [IDX_W-1:0]   out_index;
    score_t             out_score;
    logic               out_filled;

    stk_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_score  (score_t'(s_tdata)),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    stk_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop)
    );

    stk_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_index  (out_index),
        .out_score  (out_score),
        .out_filled (out_filled),
        .out_last   (m_tlast)
    );

    assign m_tdata    = MTDATA_W'({out_score, out_index});
    assign m_tuser[0] = out_filled;

endmodule

@@ sim/streaming_top_k_selector_core_tb.sv @@
// Self-checking testbench for the streaming top-k selector core.
`timescale 1ns / 100ps

import stk_pkg::*;

typedef struct packed {
    index_t idx;
    score_t sc;
    logic   filled;
    logic   tail;
} rank_rec_t;

// Tracks the ranked list the core should hold and the rank results it owes.
class top_k_ranking;
    score_t            held_score[K_MAX];
    index_t            held_idx[K_MAX];
    bit                held_ok[K_MAX];
    logic [POS_W-1:0]  position;
    logic [KCFG_W-1:0] k_reg;
    rank_rec_t         expected_ranks[$];
    int                errors;
    int                items_seen;
    int                runs_seen;
    int                results_seen;

    function new();
        clear_list();
        k_reg = K_RESET;
        errors = 0;
        items_seen = 0;
        runs_seen = 0;
        results_seen = 0;
    endfunction

    function void clear_list();
        for (int i = 0; i < K_MAX; i++)
        begin
            held_score[i] = SCORE_MOST_NEG;
            held_idx[i] = '0;
            held_ok[i] = 1'b0;
        end
        position = '0;
    endfunction

    function int ranks_in_use();
        if (k_reg == '0)
        begin
            return 1;
        end
        if (int'(k_reg) > K_MAX)
        begin
            return K_MAX;
        end
        return int'(k_reg);
    endfunction

    function void set_k(logic [KCFG_W-1:0] v);
        k_reg = v;
    endfunction

    function int pending();
        return expected_ranks.size();
    endfunction

    function void take_score(score_t sc, logic tail);
        int        k;
        int        slot;
        int        j;
        rank_rec_t rec;
        k = ranks_in_use();
        slot = k;
        // Scanning downward leaves slot at the first rank the score beats.
        for (j = k - 1; j >= 0; j--)
        begin
            if (!held_ok[j] || sc > held_score[j])
            begin
                slot = j;
            end
        end
        if (slot < k)
        begin
            // Entries shift across every slot, not just the first k.
            for (j = K_MAX - 1; j > slot; j--)
            begin
                held_score[j] = held_score[j - 1];
                held_idx[j] = held_idx[j - 1];
                held_ok[j] = held_ok[j - 1];
            end
            held_score[slot] = sc;
            held_idx[slot] = index_t'(position);
            held_ok[slot] = 1'b1;
        end
        if (position != POS_LIMIT)
        begin
            position++;
        end
        items_seen++;
        if (tail)
        begin
            for (j = 0; j < k; j++)
            begin
                rec.idx = held_ok[j] ? held_idx[j] : '0;
                rec.sc = held_ok[j] ? held_score[j] : score_t'(SCORE_MOST_NEG);
                rec.filled = held_ok[j];
                rec.tail = (j == k - 1);
                expected_ranks.push_back(rec);
            end
            clear_list();
            runs_seen++;
        end
    endfunction

    function void compare_rank(index_t idx, score_t sc, logic filled, logic tail);
        rank_rec_t want;
        results_seen++;
        if (expected_ranks.size() == 0)
        begin
            $display("%0t: unexpected rank result, actual index %0d score %0d filled %0b last %0b",
                     $time, idx, sc, filled, tail);
            errors++;
            return;
        end
        want = expected_ranks.pop_front();
        if (idx !== want.idx)
        begin
            $display("%0t: rank_index mismatch, expected %0d, actual %0d", $time, want.idx, idx);
            errors++;
        end
        if (sc !== want.sc)
        begin
            $display("%0t: rank_score mismatch, expected %0d, actual %0d", $time, want.sc, sc);
            errors++;
        end
        if (filled !== want.filled)
        begin
            $display("%0t: slot_filled mismatch, expected %0b, actual %0b",
                     $time, want.filled, filled);
            errors++;
        end
        if (tail !== want.tail)
        begin
            $display("%0t: last_rank mismatch, expected %0b, actual %0b", $time, want.tail, tail);
            errors++;
        end
    endfunction
endclass

module streaming_top_k_selector_core_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE         = 16;
    localparam int RANDOM_ITEMS   = 170;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [KCFG_W-1:0]   cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [SCORE_W-1:0]  s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [MTDATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;

    top_k_ranking sb;
    bit           no_idle = 1'b0;
    bit           hold_req = 1'b0;
    int           quiet_cycles = 0;

    streaming_top_k_selector_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic score_t pick_score();
        case ($urandom_range(0, 9))
            0: return score_t'(SCORE_MOST_NEG);
            1: return score_t'(32'h7FFF_FFFF);
            2, 3: return score_t'($urandom_range(0, 6)) - 3;
            default: return score_t'($urandom());
        endcase
    endfunction

    // Both monitors sample at the rising edge, before the design updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.take_score(score_t'(s_tdata), s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                sb.compare_rank(m_tdata[IDX_W-1:0], score_t'(m_tdata[IDX_W +: SCORE_W]),
                                m_tuser[0], m_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // Result receiver: random stalls per transaction, plus a long hold-off on request.
    initial
    begin
        int rx_wait;
        int hold_left;
        rx_wait = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                rx_wait = draw_gap();
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input score_t sc, input logic tail);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sc;
        s_tlast <= tail;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_stream(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_item(pick_score(), i == len - 1);
        end
    endtask

    // Reading the scoreboard at the falling edge keeps clear of the monitor.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    task automatic write_k(input logic [KCFG_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_k(v);
    endtask

    initial
    begin
        logic [KCFG_W-1:0] k_plan[7];
        int                sent;
        int                phase;
        int                len;
        sb = new();
        k_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5};
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset k of four: a lone most negative score still fills a slot.
        send_item(score_t'(SCORE_MOST_NEG), 1'b1);
        // Extremes, equal scores and drops below the k-th entry.
        send_item(score_t'(32'h7FFF_FFFF), 1'b0);
        send_item(score_t'(0), 1'b0);
        send_item(score_t'(-1), 1'b0);
        send_item(score_t'(0), 1'b0);
        send_item(score_t'(SCORE_MOST_NEG), 1'b0);
        send_item(score_t'(32'h7FFF_FFFF), 1'b0);
        send_item(score_t'(1), 1'b1);

        // A register value of zero acts as one.
        write_k(4'd0);
        send_item(score_t'(5), 1'b0);
        send_item(score_t'(10), 1'b0);
        send_item(score_t'(7), 1'b1);

        // Values above the list depth act as full depth; a short stream leaves empty ranks.
        write_k(4'd15);
        for (int i = 0; i < 5; i++)
        begin
            send_item(score_t'(i * 3 - 12), i == 4);
        end

        // Shrink k mid-stream, then grow it again: deep entries must come back.
        write_k(4'd8);
        for (int i = 6; i >= 1; i--)
        begin
            send_item(score_t'(i * 10), 1'b0);
        end
        write_k(4'd2);
        send_item(score_t'(55), 1'b0);
        write_k(4'd8);
        send_item(score_t'(5), 1'b1);

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 2)
            begin
                // Stall the results while many short streams pile up at the input.
                wait_drained();
                @(negedge clk);
                hold_req = 1'b1;
                @(posedge clk);
                no_idle = 1'b1;
                len = 0;
                while (len < 40)
                begin
                    send_item(pick_score(), 1'($urandom_range(0, 1)));
                    len++;
                end
                send_item(pick_score(), 1'b1);
                sent += len + 1;
                no_idle = 1'b0;
                // The sender pauses here until every owed result is out.
                wait_drained();
            end
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 6))
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 12);
                send_stream(len);
                sent += len;
            end
            // Sometimes leave a stream open across the register write.
            if ($urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(pick_score(), 1'b0);
                    sent++;
                end
            end
            no_idle = 1'b0;
            write_k((phase < 7) ? k_plan[phase] : KCFG_W'($urandom_range(0, 15)));
            phase++;
        end
        send_stream($urandom_range(1, 6));

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d score transactions in %0d streams, %0d rank results checked.",
                 sb.items_seen, sb.runs_seen, sb.results_seen);
        $display("Included k from 0 to 15, k changed inside a stream and a stalled output.");
        if (sb.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/stk_pkg.sv
rtl/stk_front.sv
rtl/stk_queue.sv
rtl/stk_fifo.sv
rtl/stk_back.sv
rtl/streaming_top_k_selector_core.sv
sim/streaming_top_k_selector_core_tb.sv
